// ----- rtl/core/lsas_pkg.sv -----
// Shared types and constants for the LED strip animation sequencer.
// No dependencies; every module of the block imports this package.
package lsas_pkg;

   localparam int LED_CNT_W  = 7;
   localparam int PERIOD_W   = 9;
   localparam int INDEX_W    = 6;
   localparam int COUNT_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   // Restoring divider: dividend holds led_count * entered_count
   localparam int DIVIDEND_W = 14;
   localparam int DIVISOR_W  = 8;
   localparam int STEP_W     = $clog2(DIVIDEND_W);

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [PERIOD_W-1:0]  ELAPSED_MAX       = 9'd511;
   localparam logic [LED_CNT_W-1:0] RESET_LED_COUNT   = 7'd32;
   localparam logic [PERIOD_W-1:0]  RESET_GROW_PERIOD  = 9'd30;
   localparam logic [PERIOD_W-1:0]  RESET_CHASE_PERIOD = 9'd40;
   localparam logic [PERIOD_W-1:0]  RESET_BLINK_PERIOD = 9'd400;

   localparam logic [CSR_IDX_W-1:0] CSR_LED_COUNT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROW_PERIOD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHASE_PERIOD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_PERIOD = 3'd3;

   typedef enum logic [2:0] {
      ACT_TICK     = 3'd0,
      ACT_PROGRESS = 3'd1,
      ACT_GREEN    = 3'd2,
      ACT_BLINK    = 3'd3,
      ACT_CHASE    = 3'd4,
      ACT_OFF      = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      MODE_OFF      = 3'd0,
      MODE_PROGRESS = 3'd1,
      MODE_GREEN    = 3'd2,
      MODE_BLINK    = 3'd3,
      MODE_CHASE    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      COL_BLACK = 2'd0,
      COL_BLUE  = 2'd1,
      COL_GREEN = 2'd2,
      COL_RED   = 2'd3
   } colour_type;

   typedef enum logic [1:0] {
      FS_IDLE   = 2'd0,
      FS_DIVIDE = 2'd1,
      FS_PUSH   = 2'd2
   } front_state_type;

   typedef struct packed {
      logic [LED_CNT_W-1:0] led_count;
      logic [PERIOD_W-1:0]  grow_period;
      logic [PERIOD_W-1:0]  chase_period;
      logic [PERIOD_W-1:0]  blink_period;
   } cfg_type;

   // One frame to draw: LEDs [lo, hi) get colour on, the rest black
   typedef struct packed {
      logic [LED_CNT_W-1:0] n;
      logic [LED_CNT_W-1:0] lo;
      logic [LED_CNT_W-1:0] hi;
      colour_type           on;
   } frame_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_rsp_type;

endpackage

// ----- rtl/core/lsas_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by progress and chase.
// Depends on lsas_pkg.
module lsas_div import lsas_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    rem_diff;
   logic                  fits;

   assign rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dsr_ff};
   assign fits      = rem_shift >= {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ----- rtl/core/lsas_front.sv -----
// Front end: accepts items, keeps animation state and timers, issues frames.
// Depends on lsas_pkg and the divider lsas_div.
module lsas_front import lsas_pkg::*; #(
   parameter int MAX_LEDS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [COUNT_W-1:0] req_entered_count,
   input  logic [COUNT_W-1:0] req_total_count,
   output logic               push,
   output frame_type          push_frame,
   input  logic               fifo_full
);

   front_state_type      state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [LED_CNT_W-1:0] position_ff, position_in;
   logic [COUNT_W-1:0]   done_ff, done_in;
   logic [COUNT_W-1:0]   goal_ff, goal_in;
   logic                 lit_ff, lit_in;
   logic [PERIOD_W-1:0]  elapsed_ff, elapsed_in;
   frame_type            frame_ff, frame_in;

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   logic                  accept;
   logic                  go_push;
   logic                  go_divide;
   logic [LED_CNT_W-1:0]  n;
   logic [PERIOD_W-1:0]   elapsed_inc;
   logic [DIVIDEND_W-1:0] product;
   logic [LED_CNT_W-1:0]  grow_lit;
   logic [LED_CNT_W-1:0]  chase_p;
   logic [LED_CNT_W-1:0]  chase_next;
   logic [LED_CNT_W-1:0]  prog_lit;

   lsas_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept = req_valid && req_ready;

   always_comb begin
      if (cfg.led_count == '0) begin
         n = LED_CNT_W'(1);
      end else if (cfg.led_count > LED_CNT_W'(MAX_LEDS)) begin
         n = LED_CNT_W'(MAX_LEDS);
      end else begin
         n = cfg.led_count;
      end
   end

   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? ELAPSED_MAX : elapsed_ff + 1'b1;
   assign product     = DIVIDEND_W'(n) * DIVIDEND_W'(done_ff);
   assign grow_lit    = (position_ff >= n) ? n : position_ff + 1'b1;
   assign chase_p     = div_rsp.remainder[LED_CNT_W-1:0];
   assign chase_next  = (chase_p + 1'b1 == frame_ff.n) ? '0 : chase_p + 1'b1;
   assign prog_lit    = (div_rsp.quotient >= DIVIDEND_W'(frame_ff.n)) ?
                        frame_ff.n : div_rsp.quotient[LED_CNT_W-1:0];

   // Datapath and classification
   always_comb begin
      mode_in     = mode_ff;
      position_in = position_ff;
      done_in     = done_ff;
      goal_in     = goal_ff;
      lit_in      = lit_ff;
      elapsed_in  = elapsed_ff;
      frame_in    = frame_ff;
      go_push     = 1'b0;
      go_divide   = 1'b0;
      div_req     = '{start: 1'b0, dividend: product, divisor: goal_ff};
      case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               frame_in = '{n: n, lo: '0, hi: '0, on: COL_BLACK};
               case (req_action)
                  ACT_PROGRESS: begin
                     mode_in = MODE_PROGRESS;
                     done_in = req_entered_count;
                     goal_in = (req_total_count == '0) ? COUNT_W'(1) : req_total_count;
                  end
                  ACT_GREEN: begin
                     mode_in     = MODE_GREEN;
                     position_in = '0;
                     elapsed_in  = ELAPSED_MAX;
                  end
                  ACT_BLINK: begin
                     mode_in    = MODE_BLINK;
                     lit_in     = 1'b0;
                     elapsed_in = ELAPSED_MAX;
                  end
                  ACT_CHASE: begin
                     mode_in     = MODE_CHASE;
                     position_in = '0;
                     elapsed_in  = ELAPSED_MAX;
                  end
                  ACT_OFF: begin
                     mode_in = MODE_OFF;
                     go_push = 1'b1;
                  end
                  ACT_TICK: begin
                     elapsed_in = elapsed_inc;
                     case (mode_ff)
                        MODE_PROGRESS: begin
                           div_req.start = 1'b1;
                           go_divide     = 1'b1;
                        end
                        MODE_GREEN: begin
                           if (elapsed_inc >= cfg.grow_period) begin
                              elapsed_in  = '0;
                              frame_in.hi = grow_lit;
                              frame_in.on = COL_GREEN;
                              go_push     = 1'b1;
                              if (position_ff < n) begin
                                 position_in = position_ff + 1'b1;
                              end else begin
                                 mode_in = MODE_OFF;
                              end
                           end
                        end
                        MODE_BLINK: begin
                           if (elapsed_inc >= cfg.blink_period) begin
                              elapsed_in  = '0;
                              lit_in      = !lit_ff;
                              frame_in.hi = n;
                              frame_in.on = lit_ff ? COL_BLACK : COL_RED;
                              go_push     = 1'b1;
                           end
                        end
                        MODE_CHASE: begin
                           if (elapsed_inc >= cfg.chase_period) begin
                              elapsed_in       = '0;
                              div_req.start    = 1'b1;
                              div_req.dividend = DIVIDEND_W'(position_ff);
                              div_req.divisor  = DIVISOR_W'(n);
                              go_divide        = 1'b1;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
                  default: begin
                  end
               endcase
            end
         end
         FS_DIVIDE: begin
            if (div_rsp.done) begin
               if (mode_ff == MODE_PROGRESS) begin
                  frame_in.lo = '0;
                  frame_in.hi = prog_lit;
                  frame_in.on = COL_BLUE;
               end else begin
                  frame_in.lo = chase_p;
                  frame_in.hi = chase_p + 1'b1;
                  frame_in.on = COL_RED;
                  position_in = chase_next;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FS_IDLE: begin
            if (go_divide) begin
               state_in = FS_DIVIDE;
            end else if (go_push) begin
               state_in = FS_PUSH;
            end
         end
         FS_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = FS_PUSH;
            end
         end
         FS_PUSH: begin
            if (!fifo_full) begin
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready  = (state_ff == FS_IDLE);
      push       = (state_ff == FS_PUSH) && !fifo_full;
      push_frame = frame_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FS_IDLE;
         mode_ff     <= MODE_OFF;
         position_ff <= '0;
         done_ff     <= '0;
         goal_ff     <= COUNT_W'(1);
         lit_ff      <= 1'b0;
         elapsed_ff  <= ELAPSED_MAX;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         position_ff <= position_in;
         done_ff     <= done_in;
         goal_ff     <= goal_in;
         lit_ff      <= lit_in;
         elapsed_ff  <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

endmodule

// ----- rtl/core/lsas_fifo.sv -----
// Short frame queue between the front end and the frame streamer.
// Depends on lsas_pkg.
module lsas_fifo import lsas_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_frame,
   output logic      full,
   input  logic      pop,
   output frame_type pop_frame,
   output logic      empty
);

   frame_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_frame;
      end
   end

   assign pop_frame = mem_ff[rd_ptr_ff];

endmodule

// ----- rtl/core/lsas_back.sv -----
// Frame streamer: pops a frame and sends one item per LED through an output register.
// Depends on lsas_pkg.
module lsas_back import lsas_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   output logic               pop,
   input  frame_type          pop_frame,
   input  logic               empty,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [INDEX_W-1:0] rsp_led_index,
   output logic [1:0]         rsp_colour,
   output logic               rsp_last_led
);

   logic               active_ff, active_in;
   frame_type          cur_ff, cur_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic               valid_ff, valid_in;
   logic [INDEX_W-1:0] out_idx_ff, out_idx_in;
   colour_type         out_col_ff, out_col_in;
   logic               out_last_ff, out_last_in;
   logic               slot_free;
   logic               lit;
   logic               last;

   assign slot_free = !valid_ff || rsp_ready;
   assign lit  = (LED_CNT_W'(idx_ff) >= cur_ff.lo) && (LED_CNT_W'(idx_ff) < cur_ff.hi);
   assign last = (LED_CNT_W'(idx_ff) == cur_ff.n - 1'b1);
   assign pop  = !active_ff && !empty;

   always_comb begin
      active_in   = active_ff;
      cur_in      = cur_ff;
      idx_in      = idx_ff;
      valid_in    = valid_ff;
      out_idx_in  = out_idx_ff;
      out_col_in  = out_col_ff;
      out_last_in = out_last_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         active_in = 1'b1;
         cur_in    = pop_frame;
         idx_in    = '0;
      end else if (active_ff && slot_free) begin
         // advance one LED into the output register
         valid_in    = 1'b1;
         out_idx_in  = idx_ff;
         out_col_in  = lit ? cur_ff.on : COL_BLACK;
         out_last_in = last;
         idx_in      = idx_ff + 1'b1;
         if (last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      out_idx_ff  <= out_idx_in;
      out_col_ff  <= out_col_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_led_index = out_idx_ff;
   assign rsp_colour    = out_col_ff;
   assign rsp_last_led  = out_last_ff;

endmodule

// ----- rtl/core/led_strip_animation_sequencer.sv -----
// LED strip animation sequencer. Each item is a mode command or a one-millisecond
// tick; a drawing event produces a whole frame, one rsp item per LED from LED 0, the
// last flagged by rsp_last_led. Commands other than off leave the front end idle. A
// drawing event goes through the push state, after the divide state when a progress
// bar or chase position goes through the shared restoring divider (one quotient bit
// per cycle); the push state waits while the queue is full. The streamer then sends
// one LED per cycle while rsp_ready is held high; a two-frame queue lets the front
// end take the next item while a frame is streaming.
// Configuration (csr_index 0 led_count, 1 grow_period, 2 chase_period, 3 blink_period)
// is always ready and is meant to be written while the block is idle.
module led_strip_animation_sequencer import lsas_pkg::*; #(
   parameter int MAX_LEDS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_action,
   input  logic [COUNT_W-1:0]    req_entered_count,
   input  logic [COUNT_W-1:0]    req_total_count,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [INDEX_W-1:0]    rsp_led_index,
   output logic [1:0]            rsp_colour,
   output logic                  rsp_last_led
);

   cfg_type   cfg_ff, cfg_in;
   logic      push;
   frame_type push_frame;
   logic      fifo_full;
   logic      pop;
   frame_type pop_frame;
   logic      fifo_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LED_COUNT:    cfg_in.led_count    = csr_data[LED_CNT_W-1:0];
            CSR_GROW_PERIOD:  cfg_in.grow_period  = csr_data[PERIOD_W-1:0];
            CSR_CHASE_PERIOD: cfg_in.chase_period = csr_data[PERIOD_W-1:0];
            CSR_BLINK_PERIOD: cfg_in.blink_period = csr_data[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{led_count:    RESET_LED_COUNT,
                     grow_period:  RESET_GROW_PERIOD,
                     chase_period: RESET_CHASE_PERIOD,
                     blink_period: RESET_BLINK_PERIOD};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lsas_front #(
      .MAX_LEDS (MAX_LEDS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_entered_count (req_entered_count),
      .req_total_count   (req_total_count),
      .push              (push),
      .push_frame        (push_frame),
      .fifo_full         (fifo_full)
   );

   lsas_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .full       (fifo_full),
      .pop        (pop),
      .pop_frame  (pop_frame),
      .empty      (fifo_empty)
   );

   lsas_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop           (pop),
      .pop_frame     (pop_frame),
      .empty         (fifo_empty),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_led_index (rsp_led_index),
      .rsp_colour    (rsp_colour),
      .rsp_last_led  (rsp_last_led)
   );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for led_strip_animation_sequencer: directed table, then random
// phases under several register settings, each LED item checked against a local predictor.
// Depends on lsas_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
   import lsas_pkg::*;

   localparam int CLK_PERIOD      = 12;
   localparam int RESET_CYCLES    = 5;
   localparam int SETTLE_CYCLES   = 40;
   localparam int CYCLE_LIMIT     = 20_000_000;
   localparam int MAX_LEDS        = 64;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int NUM_DIRECTED    = 33;

   // Actions the block must ignore
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   typedef enum bit {ROW_ITEM, ROW_CSR} row_kind_type;

   // exp_len < 0: take the frame from the predictor
   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   code;
      logic [8:0]   arg_a;
      logic [7:0]   arg_b;
      int           exp_len;
      int           exp_lo;
      int           exp_hi;
      colour_type   exp_on;
   } script_row_type;

   typedef struct packed {
      logic [INDEX_W-1:0] led_index;
      colour_type         colour;
      logic               last;
   } led_result_type;

   localparam script_row_type DIRECTED [NUM_DIRECTED] = '{
      // kind    code              a        b      len lo  hi  on
      '{ROW_ITEM, ACT_OFF,          9'd0,    8'd0,   32, 0,  0,  COL_BLACK},
      '{ROW_ITEM, ACT_TICK,         9'd0,    8'd0,    0, 0,  0,  COL_BLACK},
      '{ROW_ITEM, ACT_SPARE_6,      9'd0,    8'd0,    0, 0,  0,  COL_BLACK},
      '{ROW_ITEM, ACT_SPARE_7,      9'd255,  8'd255,  0, 0,  0,  COL_BLACK},
      '{ROW_ITEM, ACT_PROGRESS,     9'd0,    8'd0,    0, 0,  0,  COL_BLACK},
      '{ROW_ITEM, ACT_TICK,         9'd0,    8'd0,   32, 0,  0,  COL_BLUE},
      '{ROW_ITEM, ACT_PROGRESS,     9'd255,  8'd0,    0, 0,  0,  COL_BLACK},
      '{ROW_ITEM, ACT_TICK,         9'd0,    8'd0,   32, 0,  32, COL_BLUE},
      '{ROW_ITEM, ACT_PROGRESS,     9'd3,    8'd8,    0, 0,  0,  COL_BLACK},
      '{ROW_ITEM, ACT_TICK,         9'd0,    8'd0,   32, 0,  12, COL_BLUE},
      '{ROW_ITEM, ACT_GREEN,        9'd0,    8'd0,    0, 0,  0,  COL_BLACK},
      '{ROW_ITEM, ACT_TICK,         9'd0,    8'd0,   32, 0,  1,  COL_GREEN},
      '{ROW_ITEM, ACT_TICK,         9'd0,    8'd0,    0, 0,  0,  COL_BLACK},
      '{ROW_ITEM, ACT_BLINK,        9'd0,    8'd0,    0, 0,  0,  COL_BLACK},
      '{ROW_ITEM, ACT_TICK,         9'd0,    8'd0,   32, 0,  32, COL_RED},
      '{ROW_ITEM, ACT_CHASE,        9'd0,    8'd0,    0, 0,  0,  COL_BLACK},
      '{ROW_ITEM, ACT_TICK,         9'd0,    8'd0,   32, 0,  1,  COL_RED},
      '{ROW_CSR,  CSR_LED_COUNT,    9'd2,    8'd0,    0, 0,  0,  COL_BLACK},
      '{ROW_CSR,  CSR_GROW_PERIOD,  9'd0,    8'd0,    0, 0,  0,  COL_BLACK},
      '{ROW_CSR,  CSR_CHASE_PERIOD, 9'd0,    8'd0,    0, 0,  0,  COL_BLACK},
      // green run to its end on a two-LED strip
      '{ROW_ITEM, ACT_GREEN,        9'd0,    8'd0,    0, 0,  0,  COL_BLACK},
      '{ROW_ITEM, ACT_TICK,         9'd0,    8'd0,    2, 0,  1,  COL_GREEN},
      '{ROW_ITEM, ACT_TICK,         9'd0,    8'd0,    2, 0,  2,  COL_GREEN},
      '{ROW_ITEM, ACT_TICK,         9'd0,    8'd0,    2, 0,  2,  COL_GREEN},
      '{ROW_ITEM, ACT_TICK,         9'd0,    8'd0,    0, 0,  0,  COL_BLACK},
      // chase wraps back to LED 0
      '{ROW_ITEM, ACT_CHASE,        9'd0,    8'd0,    0, 0,  0,  COL_BLACK},
      '{ROW_ITEM, ACT_TICK,         9'd0,    8'd0,    2, 0,  1,  COL_RED},
      '{ROW_ITEM, ACT_TICK,         9'd0,    8'd0,    2, 1,  2,  COL_RED},
      '{ROW_ITEM, ACT_TICK,         9'd0,    8'd0,    2, 0,  1,  COL_RED},
      // LED count above the maximum, then zero
      '{ROW_CSR,  CSR_LED_COUNT,    9'd127,  8'd0,    0, 0,  0,  COL_BLACK},
      '{ROW_ITEM, ACT_OFF,          9'd0,    8'd0,   64, 0,  0,  COL_BLACK},
      '{ROW_CSR,  CSR_LED_COUNT,    9'd0,    8'd0,    0, 0,  0,  COL_BLACK},
      '{ROW_ITEM, ACT_OFF,          9'd0,    8'd0,    1, 0,  0,  COL_BLACK}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_action = '0;
   logic [COUNT_W-1:0]    req_entered_count = '0;
   logic [COUNT_W-1:0]    req_total_count = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [INDEX_W-1:0]    rsp_led_index;
   logic [1:0]            rsp_colour;
   logic                  rsp_last_led;

   bit steady = 1'b0;
   int errors = 0;
   int cycle_count = 0;

   // Predictor state and register copies
   logic [LED_CNT_W-1:0] cfg_led_count    = RESET_LED_COUNT;
   logic [PERIOD_W-1:0]  cfg_grow_period  = RESET_GROW_PERIOD;
   logic [PERIOD_W-1:0]  cfg_chase_period = RESET_CHASE_PERIOD;
   logic [PERIOD_W-1:0]  cfg_blink_period = RESET_BLINK_PERIOD;
   mode_type             anim_mode        = MODE_OFF;
   logic [6:0]           anim_pos         = '0;
   logic [7:0]           progress_entered = '0;
   logic [7:0]           progress_total   = 8'd1;
   logic                 blink_on         = 1'b0;
   logic [PERIOD_W-1:0]  ms_elapsed       = ELAPSED_MAX;

   led_result_type expected_leds [$];

   led_strip_animation_sequencer #(
      .MAX_LEDS(MAX_LEDS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_entered_count(req_entered_count),
      .req_total_count(req_total_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_led_index(rsp_led_index),
      .rsp_colour(rsp_colour),
      .rsp_last_led(rsp_last_led)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int strip_length();
      if (cfg_led_count == 0) return 1;
      if (cfg_led_count > MAX_LEDS) return MAX_LEDS;
      return int'(cfg_led_count);
   endfunction

   function automatic void push_frame(int count, int lo, int hi, colour_type on);
      led_result_type led;
      for (int i = 0; i < count; i++) begin
         led.led_index = i[INDEX_W-1:0];
         led.colour    = (i >= lo && i < hi) ? on : COL_BLACK;
         led.last      = (i == count - 1);
         expected_leds.push_back(led);
      end
   endfunction

   function automatic void apply_register(logic [2:0] idx, logic [8:0] data);
      case (idx)
         CSR_LED_COUNT:    cfg_led_count    = data[LED_CNT_W-1:0];
         CSR_GROW_PERIOD:  cfg_grow_period  = data;
         CSR_CHASE_PERIOD: cfg_chase_period = data;
         CSR_BLINK_PERIOD: cfg_blink_period = data;
         default: ;
      endcase
   endfunction

   // Update the animation state for one item and queue the frame it draws
   function automatic void advance_animation(logic [2:0] act, logic [7:0] entered,
                                             logic [7:0] total);
      int n;
      int lit;
      int p;
      n = strip_length();
      case (act)
         ACT_PROGRESS: begin
            anim_mode        = MODE_PROGRESS;
            progress_entered = entered;
            progress_total   = (total == 0) ? 8'd1 : total;
         end
         ACT_GREEN: begin
            anim_mode  = MODE_GREEN;
            anim_pos   = '0;
            ms_elapsed = ELAPSED_MAX;
         end
         ACT_BLINK: begin
            anim_mode  = MODE_BLINK;
            blink_on   = 1'b0;
            ms_elapsed = ELAPSED_MAX;
         end
         ACT_CHASE: begin
            anim_mode  = MODE_CHASE;
            anim_pos   = '0;
            ms_elapsed = ELAPSED_MAX;
         end
         ACT_OFF: begin
            anim_mode = MODE_OFF;
            push_frame(n, 0, 0, COL_BLACK);
         end
         ACT_TICK: begin
            if (ms_elapsed < ELAPSED_MAX) ms_elapsed++;
            case (anim_mode)
               MODE_PROGRESS: begin
                  lit = n * int'(progress_entered) / int'(progress_total);
                  if (lit > n) lit = n;
                  push_frame(n, 0, lit, COL_BLUE);
               end
               MODE_GREEN: begin
                  if (ms_elapsed >= cfg_grow_period) begin
                     ms_elapsed = '0;
                     lit = int'(anim_pos) + 1;
                     if (lit > n) lit = n;
                     push_frame(n, 0, lit, COL_GREEN);
                     // full bar shown once more, then go quiet
                     if (int'(anim_pos) < n) anim_pos = anim_pos + 7'd1;
                     else anim_mode = MODE_OFF;
                  end
               end
               MODE_BLINK: begin
                  if (ms_elapsed >= cfg_blink_period) begin
                     ms_elapsed = '0;
                     blink_on = ~blink_on;
                     push_frame(n, 0, n, blink_on ? COL_RED : COL_BLACK);
                  end
               end
               MODE_CHASE: begin
                  if (ms_elapsed >= cfg_chase_period) begin
                     ms_elapsed = '0;
                     p = int'(anim_pos) % n;
                     anim_pos = 7'((p + 1) % n);
                     push_frame(n, p, p + 1, COL_RED);
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(logic [2:0] act, logic [7:0] entered, logic [7:0] total,
                            int typed_len, int typed_lo, int typed_hi, colour_type typed_on);
      int gap;
      int roll;
      int mark;
      roll = $urandom_range(0, 99);
      if (steady || roll < 50) gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_action        = act;
      req_entered_count = entered;
      req_total_count   = total;
      do @(posedge clock); while (!req_ready);
      mark = expected_leds.size();
      advance_animation(act, entered, total);
      if (typed_len >= 0) begin
         // replace the predicted frame with the one from the table
         while (expected_leds.size() > mark) void'(expected_leds.pop_back());
         push_frame(typed_len, typed_lo, typed_hi, typed_on);
      end
      @(negedge clock);
   endtask

   task automatic write_register(logic [2:0] idx, logic [8:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Hold off until every frame is out and the front end has gone quiet
   task automatic drain_frames();
      req_valid = 1'b0;
      while (expected_leds.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      script_row_type row;
      int items;
      int roll;
      int burst;
      logic [2:0] cmd;
      logic [8:0] led_data;
      logic [8:0] grow_data;
      logic [8:0] chase_data;
      logic [8:0] blink_data;

      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < NUM_DIRECTED; r++) begin
         row = DIRECTED[r];
         if (row.kind == ROW_CSR) begin
            drain_frames();
            write_register(row.code, row.arg_a);
         end else begin
            send_item(row.code, row.arg_a[7:0], row.arg_b, row.exp_len, row.exp_lo,
                      row.exp_hi, row.exp_on);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_frames();
         case (phase)
            0: begin
               led_data = 9'd64; grow_data = 9'd0; chase_data = 9'd0; blink_data = 9'd0;
            end
            1: begin
               led_data = 9'd1; grow_data = 9'd511; chase_data = 9'd511; blink_data = 9'd511;
            end
            2: begin
               // upper data bits must be dropped by the LED count register
               led_data = 9'h1FF; grow_data = 9'd1; chase_data = 9'd1; blink_data = 9'd1;
            end
            3: begin
               led_data   = 9'($urandom_range(1, 12));
               grow_data  = 9'($urandom_range(0, 4));
               chase_data = 9'($urandom_range(0, 4));
               blink_data = 9'($urandom_range(0, 4));
            end
            4: begin
               led_data   = 9'($urandom_range(0, 511));
               grow_data  = 9'($urandom_range(0, 8));
               chase_data = 9'($urandom_range(0, 8));
               blink_data = 9'($urandom_range(0, 8));
            end
            5: begin
               led_data = 9'd0; grow_data = 9'd2; chase_data = 9'd3; blink_data = 9'd1;
            end
            default: begin
               led_data   = 9'($urandom_range(1, 64));
               grow_data  = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
                                                        : 9'($urandom_range(0, 6));
               chase_data = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
                                                        : 9'($urandom_range(0, 6));
               blink_data = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
                                                        : 9'($urandom_range(0, 6));
            end
         endcase
         write_register(CSR_LED_COUNT, led_data);
         write_register(CSR_GROW_PERIOD, grow_data);
         write_register(CSR_CHASE_PERIOD, chase_data);
         write_register(CSR_BLINK_PERIOD, blink_data);
         steady = (phase == 2 || phase == 5);

         items = 0;
         while (items < ITEMS_PER_PHASE) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) cmd = ACT_PROGRESS;
            else if (roll < 50) cmd = ACT_GREEN;
            else if (roll < 65) cmd = ACT_BLINK;
            else if (roll < 85) cmd = ACT_CHASE;
            else if (roll < 93) cmd = ACT_OFF;
            else if (roll < 97) cmd = ACT_TICK;
            else cmd = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
            send_item(cmd, 8'($urandom_range(0, 255)),
                      ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255)),
                      -1, 0, 0, COL_BLACK);
            if (cmd != ACT_SPARE_6 && cmd != ACT_SPARE_7) items++;

            // ticks drive the selected animation, sometimes a green run to its end
            burst = $urandom_range(1, 8);
            if (cmd == ACT_GREEN && $urandom_range(0, 2) == 0) burst = strip_length() + 2;
            repeat (burst) begin
               cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7)) : ACT_TICK;
               send_item(cmd, 8'($urandom), 8'($urandom), -1, 0, 0, COL_BLACK);
               if (cmd != ACT_SPARE_6 && cmd != ACT_SPARE_7) items++;
            end
         end
      end

      steady = 1'b0;
      drain_frames();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Result side back-pressure: runs of ready, short stalls, now and then a long one
   initial begin
      int ready_left;
      int roll;
      ready_left = 0;
      forever begin
         @(negedge clock);
         if (steady) begin
            rsp_ready = 1'b1;
            ready_left = 0;
         end else if (ready_left > 0) begin
            ready_left--;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
               rsp_ready = 1'b1;
               ready_left = $urandom_range(0, 12);
            end else if (roll < 95) begin
               rsp_ready = 1'b0;
               ready_left = $urandom_range(0, 2);
            end else begin
               rsp_ready = 1'b0;
               ready_left = $urandom_range(10, 40);
            end
         end
      end
   end

   always @(posedge clock) begin
      led_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_leds.size() == 0) begin
            $display("%0t: unexpected LED item: index %0d colour %0d last %0d",
                     $time, rsp_led_index, rsp_colour, rsp_last_led);
            errors++;
         end else begin
            want = expected_leds.pop_front();
            if (rsp_led_index !== want.led_index) begin
               $display("%0t: led_index mismatch: expected %0d, got %0d",
                        $time, want.led_index, rsp_led_index);
               errors++;
            end
            if (rsp_colour !== want.colour) begin
               $display("%0t: colour mismatch at LED %0d: expected %0d, got %0d",
                        $time, want.led_index, want.colour, rsp_colour);
               errors++;
            end
            if (rsp_last_led !== want.last) begin
               $display("%0t: last_led mismatch at LED %0d: expected %0d, got %0d",
                        $time, want.led_index, want.last, rsp_last_led);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d LED items outstanding", $time,
                  expected_leds.size());
         $display("FAILURE");
         $finish;
      end
   end

endmodule
